// ===== hdl/gdic_pkg.sv =====
// Package for the graph degree invariant compare block: field widths, command
// codes, shared-unit operations and the result record. No dependencies.
`default_nettype none
package gdic_pkg;

	localparam int CMD_W    = 2;
	localparam int VERTEX_W = 10;

	localparam int DEF_NUM_VERTICES = 1024;
	localparam int DEF_MAX_EDGES    = 1024;
	localparam int DEF_DEGREE_BINS  = 2048;

	localparam logic [CMD_W-1:0] CMD_EDGE_ONE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EDGE_TWO = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPARE  = 2'd2;

	typedef enum logic [1:0] {
		ALU_DEG_INC1,
		ALU_DEG_INC2,
		ALU_TALLY_UP,
		ALU_TALLY_DN
	} alu_op_t;

	typedef struct packed {
		logic same_degrees;
		logic same_vertex_count;
		logic same_edge_count;
		logic invariants_match;
		logic overflow;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/gdic_if.sv =====
// Valid/ready channel interfaces for edge and compare transactions and for
// the verdict. Depends on gdic_pkg for the field widths.
`default_nettype none
interface gdic_in_if;
	logic                           valid;
	logic                           ready;
	logic [gdic_pkg::CMD_W-1:0]     command;
	logic [gdic_pkg::VERTEX_W-1:0]  vertex_a;
	logic [gdic_pkg::VERTEX_W-1:0]  vertex_b;

	modport source (output valid, command, vertex_a, vertex_b, input ready);
	modport sink (input valid, command, vertex_a, vertex_b, output ready);
endinterface

interface gdic_out_if;
	logic valid;
	logic ready;
	logic same_degrees;
	logic same_vertex_count;
	logic same_edge_count;
	logic invariants_match;
	logic overflow;

	modport source (output valid, same_degrees, same_vertex_count, same_edge_count,
		invariants_match, overflow, input ready);
	modport sink (input valid, same_degrees, same_vertex_count, same_edge_count,
		invariants_match, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/gdic_ram.sv =====
// Simple dual-port memory: one write port and one registered read port.
// Stand-alone; no package dependencies.
`default_nettype none
module gdic_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/gdic_alu.sv =====
// Shared adder of the block: saturating degree increments and signed tally
// steps all pass through the one add and limit compare. Depends on gdic_pkg.
`default_nettype none
module gdic_alu #(
	parameter int DEG_W     = 11,
	parameter int TALLY_W   = 12,
	parameter int DEG_LIMIT = 2047
) (
	input  wire gdic_pkg::alu_op_t      op,
	input  wire logic [DEG_W-1:0]       deg_in,
	input  wire logic [TALLY_W-1:0]     tally_in,
	output logic      [DEG_W-1:0]       deg_out,
	output logic      [TALLY_W-1:0]     tally_out,
	output logic                        sat
);

	import gdic_pkg::*;

	localparam int AW = ((DEG_W > TALLY_W) ? DEG_W : TALLY_W) + 1;
	localparam logic signed [AW-1:0] LIMIT = AW'(DEG_LIMIT);

	logic signed [AW-1:0] operand;
	logic signed [AW-1:0] addend;
	logic signed [AW-1:0] sum;
	logic                 deg_op;

	always_comb begin
		deg_op = (op == ALU_DEG_INC1) || (op == ALU_DEG_INC2);
		if (deg_op) begin
			operand = AW'($signed({1'b0, deg_in}));
		end else begin
			operand = AW'($signed(tally_in));
		end
		unique case (op)
			ALU_DEG_INC1: addend = AW'(1);
			ALU_DEG_INC2: addend = AW'(2);
			ALU_TALLY_UP: addend = AW'(1);
			ALU_TALLY_DN: addend = -AW'(1);
			default:      addend = '0;
		endcase
		sum       = operand + addend;
		sat       = deg_op && (sum > LIMIT);
		deg_out   = sat ? LIMIT[DEG_W-1:0] : sum[DEG_W-1:0];
		tally_out = sum[TALLY_W-1:0];
	end

endmodule
`default_nettype wire

// ===== hdl/graph_degree_invariant_compare_core.sv =====
// Graph degree invariant compare core; uses gdic_pkg, gdic_if, gdic_ram and gdic_alu.
// Edge transaction: a read-modify-write of the degree memory for each end, only one for a
// self-loop, after a modulo reduction of both vertex numbers when NUM_VERTICES is below 1024.
// Compare transaction: a vertex walk with a tally read-modify-write per non-zero degree,
// then a scan checking and clearing every degree bin; the verdict sits in an output register.
// After reset a clearing pass over max(NUM_VERTICES, DEGREE_BINS) addresses zeroes the memories.
`default_nettype none
module graph_degree_invariant_compare_core #(
	parameter int NUM_VERTICES = gdic_pkg::DEF_NUM_VERTICES,
	parameter int MAX_EDGES    = gdic_pkg::DEF_MAX_EDGES,
	parameter int DEGREE_BINS  = gdic_pkg::DEF_DEGREE_BINS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	gdic_in_if.sink     items,
	gdic_out_if.source  results
);

	import gdic_pkg::*;

	// A vertex is present exactly when its degree is non-zero, since every
	// edge adds at least one to both ends. The degree memories therefore
	// carry presence as well, and the walk never tallies into bin zero of the tally.
	localparam int VW        = $clog2(NUM_VERTICES);
	localparam int BW        = $clog2(DEGREE_BINS);
	localparam int DW        = BW;
	localparam int CW        = $clog2(NUM_VERTICES + 1);
	localparam int TW        = CW + 1;
	localparam int EW        = $clog2(MAX_EDGES + 1);
	localparam int CLR_DEPTH = (NUM_VERTICES > DEGREE_BINS) ? NUM_VERTICES : DEGREE_BINS;
	localparam int CLW       = $clog2(CLR_DEPTH);
	localparam int KW        = $clog2(VERTEX_W);
	localparam int RW        = VERTEX_W + VW + 1;
	localparam bit NEED_RED  = (NUM_VERTICES < (1 << VERTEX_W));

	localparam logic [VW-1:0]  V_LAST   = VW'(NUM_VERTICES - 1);
	localparam logic [BW-1:0]  B_LAST   = BW'(DEGREE_BINS - 1);
	localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_DEPTH - 1);
	localparam logic [CLW:0]   CLR_NV   = (CLW + 1)'(NUM_VERTICES);
	localparam logic [CLW:0]   CLR_DB   = (CLW + 1)'(DEGREE_BINS);
	localparam logic [EW-1:0]  E_MAX    = EW'(MAX_EDGES);
	localparam logic [KW-1:0]  K_TOP    = KW'(VERTEX_W - 1);
	localparam logic [RW-1:0]  NV_WIDE  = RW'(NUM_VERTICES);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RED,
		S_E_RD_A,
		S_E_WR_A,
		S_E_RD_B,
		S_E_WR_B,
		S_W_RD,
		S_W_LATCH,
		S_W_T1_RD,
		S_W_T1_WR,
		S_W_T2_RD,
		S_W_T2_WR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [VERTEX_W-1:0] va_q;
	logic [VERTEX_W-1:0] vb_q;
	logic [KW-1:0]     k_q;
	logic [VW-1:0]     v_q;
	logic [BW-1:0]     bin_q;
	logic [CLW-1:0]    clr_q;
	logic [DW-1:0]     d1_q;
	logic [DW-1:0]     d2_q;
	logic [CW-1:0]     cnt1_q;
	logic [CW-1:0]     cnt2_q;
	logic [EW-1:0]     edges1_q;
	logic [EW-1:0]     edges2_q;
	logic              ovf_q;
	logic              same_deg_q;
	result_t           res_q;
	logic              res_valid_q;

	// Memory and shared-unit control.
	logic              deg_re;
	logic [VW-1:0]     deg_raddr;
	logic              deg1_we;
	logic              deg2_we;
	logic [VW-1:0]     deg_waddr;
	logic [DW-1:0]     deg_wdata;
	logic [DW-1:0]     deg1_rdata;
	logic [DW-1:0]     deg2_rdata;
	logic [DW-1:0]     deg_sel;
	logic              tally_re;
	logic [BW-1:0]     tally_raddr;
	logic              tally_we;
	logic [BW-1:0]     tally_waddr;
	logic [TW-1:0]     tally_wdata;
	logic [TW-1:0]     tally_rdata;
	alu_op_t           alu_op;
	logic [DW-1:0]     alu_deg;
	logic [TW-1:0]     alu_tally;
	logic              alu_sat;

	logic [VW-1:0]     va_idx;
	logic [VW-1:0]     vb_idx;
	logic [RW-1:0]     red_step;
	logic              self_loop;
	logic              graph_two;
	logic              out_free;

	assign va_idx    = VW'(va_q);
	assign vb_idx    = VW'(vb_q);
	assign red_step  = NV_WIDE << k_q;
	assign self_loop = (va_q == vb_q);
	assign graph_two = (cmd_q == CMD_EDGE_TWO);
	assign deg_sel   = graph_two ? deg2_rdata : deg1_rdata;
	assign out_free  = !res_valid_q || results.ready;

	// Edge and compare transactions are taken only between jobs; a verdict
	// still waiting in the output register does not hold up new edges.
	assign items.ready = (state_q == S_IDLE);

	assign results.valid             = res_valid_q;
	assign results.same_degrees      = res_q.same_degrees;
	assign results.same_vertex_count = res_q.same_vertex_count;
	assign results.same_edge_count   = res_q.same_edge_count;
	assign results.invariants_match  = res_q.invariants_match;
	assign results.overflow          = res_q.overflow;

	gdic_ram #(.DEPTH(NUM_VERTICES), .WIDTH(DW)) u_deg_one (
		.clk   (clk),
		.we    (deg1_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.re    (deg_re),
		.raddr (deg_raddr),
		.rdata (deg1_rdata)
	);

	gdic_ram #(.DEPTH(NUM_VERTICES), .WIDTH(DW)) u_deg_two (
		.clk   (clk),
		.we    (deg2_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.re    (deg_re),
		.raddr (deg_raddr),
		.rdata (deg2_rdata)
	);

	gdic_ram #(.DEPTH(DEGREE_BINS), .WIDTH(TW)) u_tally (
		.clk   (clk),
		.we    (tally_we),
		.waddr (tally_waddr),
		.wdata (tally_wdata),
		.re    (tally_re),
		.raddr (tally_raddr),
		.rdata (tally_rdata)
	);

	gdic_alu #(.DEG_W(DW), .TALLY_W(TW), .DEG_LIMIT(DEGREE_BINS - 1)) u_alu (
		.op        (alu_op),
		.deg_in    (deg_sel),
		.tally_in  (tally_rdata),
		.deg_out   (alu_deg),
		.tally_out (alu_tally),
		.sat       (alu_sat)
	);

	// Memory port steering for each sequencer step.
	always_comb begin
		deg_re      = 1'b0;
		deg_raddr   = v_q;
		deg1_we     = 1'b0;
		deg2_we     = 1'b0;
		deg_waddr   = v_q;
		deg_wdata   = '0;
		tally_re    = 1'b0;
		tally_raddr = bin_q;
		tally_we    = 1'b0;
		tally_waddr = bin_q;
		tally_wdata = '0;
		alu_op      = ALU_DEG_INC1;
		unique case (state_q)
			S_INIT: begin
				deg1_we     = ({1'b0, clr_q} < CLR_NV);
				deg2_we     = ({1'b0, clr_q} < CLR_NV);
				deg_waddr   = clr_q[VW-1:0];
				tally_we    = ({1'b0, clr_q} < CLR_DB);
				tally_waddr = clr_q[BW-1:0];
			end
			S_E_RD_A: begin
				deg_re    = 1'b1;
				deg_raddr = va_idx;
			end
			S_E_WR_A: begin
				alu_op    = self_loop ? ALU_DEG_INC2 : ALU_DEG_INC1;
				deg1_we   = !graph_two;
				deg2_we   = graph_two;
				deg_waddr = va_idx;
				deg_wdata = alu_deg;
			end
			S_E_RD_B: begin
				deg_re    = 1'b1;
				deg_raddr = vb_idx;
			end
			S_E_WR_B: begin
				alu_op    = ALU_DEG_INC1;
				deg1_we   = !graph_two;
				deg2_we   = graph_two;
				deg_waddr = vb_idx;
				deg_wdata = alu_deg;
			end
			S_W_RD: begin
				deg_re = 1'b1;
			end
			S_W_LATCH: begin
				// Clear the vertex as it is consumed, so the walk also resets the graphs.
				deg1_we = 1'b1;
				deg2_we = 1'b1;
			end
			S_W_T1_RD: begin
				tally_re    = (d1_q != '0);
				tally_raddr = d1_q;
			end
			S_W_T1_WR: begin
				alu_op      = ALU_TALLY_UP;
				tally_we    = 1'b1;
				tally_waddr = d1_q;
				tally_wdata = alu_tally;
			end
			S_W_T2_RD: begin
				tally_re    = (d2_q != '0);
				tally_raddr = d2_q;
			end
			S_W_T2_WR: begin
				alu_op      = ALU_TALLY_DN;
				tally_we    = 1'b1;
				tally_waddr = d2_q;
				tally_wdata = alu_tally;
			end
			S_SCAN_RD: begin
				tally_re = 1'b1;
			end
			S_SCAN_CHK: begin
				tally_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer with all control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cmd_q       <= CMD_EDGE_ONE;
			va_q        <= '0;
			vb_q        <= '0;
			k_q         <= '0;
			v_q         <= '0;
			bin_q       <= '0;
			clr_q       <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			cnt1_q      <= '0;
			cnt2_q      <= '0;
			edges1_q    <= '0;
			edges2_q    <= '0;
			ovf_q       <= 1'b0;
			same_deg_q  <= 1'b1;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The verdict register is reloaded in the done step instead when it is freed.
			if (results.ready && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (items.valid) begin
						cmd_q <= items.command;
						va_q  <= items.vertex_a;
						vb_q  <= items.vertex_b;
						k_q   <= K_TOP;
						if (items.command == CMD_EDGE_ONE || items.command == CMD_EDGE_TWO) begin
							state_q <= NEED_RED ? S_RED : S_E_RD_A;
						end else if (items.command == CMD_COMPARE) begin
							v_q        <= '0;
							cnt1_q     <= '0;
							cnt2_q     <= '0;
							same_deg_q <= 1'b1;
							state_q    <= S_W_RD;
						end
					end
				end
				S_RED: begin
					// One restoring step per cycle on both vertex numbers.
					if (RW'(va_q) >= red_step) begin
						va_q <= va_q - red_step[VERTEX_W-1:0];
					end
					if (RW'(vb_q) >= red_step) begin
						vb_q <= vb_q - red_step[VERTEX_W-1:0];
					end
					if (k_q == '0) begin
						state_q <= S_E_RD_A;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				S_E_RD_A: begin
					state_q <= S_E_WR_A;
				end
				S_E_WR_A: begin
					if (alu_sat || (graph_two ? (edges2_q >= E_MAX) : (edges1_q >= E_MAX))) begin
						ovf_q <= 1'b1;
					end
					if (graph_two) begin
						if (edges2_q < E_MAX) begin
							edges2_q <= edges2_q + 1'b1;
						end
					end else begin
						if (edges1_q < E_MAX) begin
							edges1_q <= edges1_q + 1'b1;
						end
					end
					state_q <= self_loop ? S_IDLE : S_E_RD_B;
				end
				S_E_RD_B: begin
					state_q <= S_E_WR_B;
				end
				S_E_WR_B: begin
					if (alu_sat) begin
						ovf_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_W_RD: begin
					state_q <= S_W_LATCH;
				end
				S_W_LATCH: begin
					d1_q    <= deg1_rdata;
					d2_q    <= deg2_rdata;
					state_q <= S_W_T1_RD;
				end
				S_W_T1_RD: begin
					if (d1_q != '0) begin
						cnt1_q  <= cnt1_q + 1'b1;
						state_q <= S_W_T1_WR;
					end else begin
						state_q <= S_W_T2_RD;
					end
				end
				S_W_T1_WR: begin
					state_q <= S_W_T2_RD;
				end
				S_W_T2_RD: begin
					if (d2_q != '0) begin
						cnt2_q  <= cnt2_q + 1'b1;
						state_q <= S_W_T2_WR;
					end else if (v_q == V_LAST) begin
						bin_q   <= '0;
						state_q <= S_SCAN_RD;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_W_RD;
					end
				end
				S_W_T2_WR: begin
					if (v_q == V_LAST) begin
						bin_q   <= '0;
						state_q <= S_SCAN_RD;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_W_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					// Any non-zero bin means the degree distributions differ; the
					// bin is cleared at the same time.
					if (tally_rdata != '0) begin
						same_deg_q <= 1'b0;
					end
					if (bin_q == B_LAST) begin
						state_q <= S_DONE;
					end else begin
						bin_q   <= bin_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_q.same_degrees      <= same_deg_q;
						res_q.same_vertex_count <= (cnt1_q == cnt2_q);
						res_q.same_edge_count   <= (edges1_q == edges2_q);
						res_q.invariants_match  <= same_deg_q && (cnt1_q == cnt2_q)
							&& (edges1_q == edges2_q);
						res_q.overflow          <= ovf_q;
						res_valid_q             <= 1'b1;
						edges1_q                <= '0;
						edges2_q                <= '0;
						ovf_q                   <= 1'b0;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== test/graph_degree_invariant_compare_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for graph_degree_invariant_compare_core: edge and compare
// transactions, with a built-in degree tally predictor. Depends on gdic_pkg and gdic_if.
module graph_degree_invariant_compare_core_tb;
	import gdic_pkg::*;

	localparam int NUM_V  = DEF_NUM_VERTICES;
	localparam int MAX_E  = DEF_MAX_EDGES;
	localparam int BINS   = DEF_DEGREE_BINS;
	localparam int DEG_W  = $clog2(BINS);
	localparam int EDGE_W = $clog2(MAX_E) + 1;

	// The fourth command code has no meaning to the block and must be ignored.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
	} graph_item_t;

	logic clk = 1'b0;
	logic arst_n;

	gdic_in_if  item_bus ();
	gdic_out_if verdict_bus ();

	graph_degree_invariant_compare_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.results (verdict_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of both graphs. Index 0 holds graph one and index 1 graph two.
	logic              present [2][NUM_V];
	logic [DEG_W-1:0]  degree [2][NUM_V];
	logic [EDGE_W-1:0] edge_count [2];
	logic              overflow_seen;

	result_t verdicts_due [$];
	int      items_sent;
	int      compares_sent;
	int      verdict_failures;
	bit      idling_on;

	task automatic note_failure(string what);
		verdict_failures++;
		if (verdict_failures <= 10)
			$display("%s", what);
	endtask

	task automatic clear_graphs();
		for (int g = 0; g < 2; g++) begin
			for (int n = 0; n < NUM_V; n++) begin
				present[g][n] = 1'b0;
				degree[g][n]  = '0;
			end
			edge_count[g] = '0;
		end
		overflow_seen = 1'b0;
	endtask

	// A degree is held at the top bin; reaching past it marks the overflow.
	function automatic logic [DEG_W-1:0] bumped(logic [DEG_W-1:0] d, int amount);
		if (int'(d) + amount > BINS - 1) begin
			overflow_seen = 1'b1;
			return DEG_W'(BINS - 1);
		end
		return DEG_W'(int'(d) + amount);
	endfunction

	task automatic record_edge(int g, logic [VERTEX_W-1:0] a_in, logic [VERTEX_W-1:0] b_in);
		int a;
		int b;
		a = int'(a_in) % NUM_V;
		b = int'(b_in) % NUM_V;
		// A self-loop counts twice against its one vertex.
		if (a == b) begin
			degree[g][a] = bumped(degree[g][a], 2);
		end else begin
			degree[g][a] = bumped(degree[g][a], 1);
			degree[g][b] = bumped(degree[g][b], 1);
		end
		present[g][a] = 1'b1;
		present[g][b] = 1'b1;
		// The edge count saturates, but the degree updates above still stand.
		if (int'(edge_count[g]) >= MAX_E) begin
			edge_count[g] = EDGE_W'(MAX_E);
			overflow_seen = 1'b1;
		end else begin
			edge_count[g] = edge_count[g] + 1'b1;
		end
	endtask

	task automatic predict_compare();
		int      tally [BINS];
		int      count [2];
		result_t v;
		foreach (tally[i])
			tally[i] = 0;
		count[0] = 0;
		count[1] = 0;
		for (int n = 0; n < NUM_V; n++) begin
			if (present[0][n]) begin
				tally[int'(degree[0][n]) % BINS]++;
				count[0]++;
			end
			if (present[1][n]) begin
				tally[int'(degree[1][n]) % BINS]--;
				count[1]++;
			end
		end
		v.same_degrees = 1'b1;
		foreach (tally[i])
			if (tally[i] != 0)
				v.same_degrees = 1'b0;
		v.same_vertex_count = (count[0] == count[1]);
		v.same_edge_count   = (edge_count[0] == edge_count[1]);
		v.invariants_match  = v.same_degrees && v.same_vertex_count && v.same_edge_count;
		v.overflow          = overflow_seen;
		verdicts_due.insert(verdicts_due.size(), v);
		clear_graphs();
	endtask

	// Sends one transaction and updates the shadow state once it is accepted. Valid stays
	// high on return so that a following item can go out back to back; every task that lets
	// time pass without sending lowers it first.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [VERTEX_W-1:0] a,
			logic [VERTEX_W-1:0] b);
		int gap;
		if (idling_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid    <= 1'b1;
		item_bus.command  <= cmd;
		item_bus.vertex_a <= a;
		item_bus.vertex_b <= b;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		case (cmd)
			CMD_EDGE_ONE: record_edge(0, a, b);
			CMD_EDGE_TWO: record_edge(1, a, b);
			CMD_COMPARE: begin
				predict_compare();
				compares_sent++;
			end
			default: ;
		endcase
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Holds the sender back until every verdict has come, then lets the block settle.
	task automatic wait_for_verdicts(int settle);
		item_bus.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// The receiving side: takes verdicts when ready is high and, while idling is on, stalls in random bursts.
	always @(posedge clk) begin : verdict_monitor
		result_t got;
		result_t want;
		int      stall_left;
		if (arst_n === 1'b1 && verdict_bus.valid === 1'b1 && verdict_bus.ready === 1'b1) begin
			got.same_degrees      = verdict_bus.same_degrees;
			got.same_vertex_count = verdict_bus.same_vertex_count;
			got.same_edge_count   = verdict_bus.same_edge_count;
			got.invariants_match  = verdict_bus.invariants_match;
			got.overflow          = verdict_bus.overflow;
			if (verdicts_due.size() == 0) begin
				note_failure($sformatf("unexpected verdict %b at %0t", got, $realtime));
			end else begin
				want = verdicts_due.pop_front();
				if (got.same_degrees !== want.same_degrees
						|| got.same_vertex_count !== want.same_vertex_count
						|| got.same_edge_count !== want.same_edge_count
						|| got.invariants_match !== want.invariants_match
						|| got.overflow !== want.overflow)
					note_failure($sformatf({"verdict mismatch at %0t: degrees %b/%b, ",
						"vertices %b/%b, edges %b/%b, match %b/%b, overflow %b/%b ",
						"(expected/actual)"}, $realtime,
						want.same_degrees, got.same_degrees,
						want.same_vertex_count, got.same_vertex_count,
						want.same_edge_count, got.same_edge_count,
						want.invariants_match, got.invariants_match,
						want.overflow, got.overflow));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			verdict_bus.ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 23) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			verdict_bus.ready <= 1'b0;
		end else begin
			verdict_bus.ready <= 1'b1;
		end
	end

	// Hand-picked graph pairs: empty graphs, extreme vertex numbers, self-loops, duplicate
	// edges, the ignored command, and a pair that differs in exactly one invariant.
	task automatic test_directed_cases();
		idling_on = 1'b0;
		send_item(CMD_UNUSED, '1, '1);
		send_item(CMD_COMPARE, '0, '0);
		send_item(CMD_EDGE_ONE, 10'd1023, 10'd1023);
		send_item(CMD_EDGE_TWO, 10'd0, 10'd0);
		send_item(CMD_COMPARE, '1, '1);
		send_item(CMD_EDGE_ONE, 10'd0, 10'd1023);
		send_item(CMD_UNUSED, 10'd17, 10'd42);
		send_item(CMD_EDGE_TWO, 10'd1023, 10'd1023);
		send_item(CMD_COMPARE, 10'd512, 10'd1);
		// Edge counts differ, one graph a path, the other a single edge.
		send_item(CMD_EDGE_ONE, 10'd1, 10'd2);
		send_item(CMD_EDGE_ONE, 10'd2, 10'd3);
		send_item(CMD_EDGE_TWO, 10'd1, 10'd2);
		send_item(CMD_COMPARE, '0, '0);
		// A path against a star: same vertex and edge counts, different degrees.
		send_item(CMD_EDGE_ONE, 10'd0, 10'd1);
		send_item(CMD_EDGE_TWO, 10'd0, 10'd1);
		send_item(CMD_EDGE_ONE, 10'd1, 10'd2);
		send_item(CMD_EDGE_TWO, 10'd0, 10'd2);
		send_item(CMD_EDGE_ONE, 10'd2, 10'd3);
		send_item(CMD_EDGE_TWO, 10'd3, 10'd0);
		send_item(CMD_COMPARE, '0, '0);
		// Repeated edges in both graphs.
		send_item(CMD_EDGE_ONE, 10'd4, 10'd5);
		send_item(CMD_EDGE_ONE, 10'd5, 10'd4);
		send_item(CMD_EDGE_TWO, 10'd6, 10'd7);
		send_item(CMD_EDGE_TWO, 10'd6, 10'd7);
		send_item(CMD_COMPARE, 10'd333, 10'd666);
		wait_for_verdicts(20);
	endtask

	// Saturation at the limits in graph one. With the default sizes the top degree bin is
	// one above twice the edge ceiling less one, so MAX_E - 1 self-loops and one plain edge
	// land a degree exactly on the top bin and the edge count exactly on its ceiling. One
	// further edge from the same vertex then pushes both past their limits, while the
	// degree of its other end still rises.
	task automatic test_saturation_limits();
		idling_on = 1'b1;
		repeat (MAX_E - 1)
			send_item(CMD_EDGE_ONE, 10'd5, 10'd5);
		send_item(CMD_EDGE_ONE, 10'd5, 10'd6);
		send_item(CMD_EDGE_TWO, 10'd700, 10'd700);
		send_item(CMD_EDGE_ONE, 10'd5, 10'd7);
		send_item(CMD_COMPARE, '0, '0);
		wait_for_verdicts(20);
	endtask

	// Builds a pair of graphs and sends their edges interleaved, then a compare. Most pairs
	// are relabellings of each other, so that the verdict is often a match; some are then
	// broken by one edge, and the rest are unrelated or one-sided.
	task automatic send_graph_pair(int kind);
		logic [VERTEX_W-1:0] pool [8];
		logic [VERTEX_W-1:0] mul;
		logic [VERTEX_W-1:0] off;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
		graph_item_t         one [$];
		graph_item_t         two [$];
		graph_item_t         it;
		int                  pool_n;
		int                  m;
		int                  idx;
		pool_n = $urandom_range(1, 8);
		foreach (pool[i])
			pool[i] = VERTEX_W'($urandom);
		m = $urandom_range(0, 24);
		for (int i = 0; i < m; i++) begin
			if (kind == 8) begin
				a = VERTEX_W'($urandom);
				b = VERTEX_W'($urandom);
			end else begin
				a = pool[$urandom_range(0, pool_n - 1)];
				b = pool[$urandom_range(0, pool_n - 1)];
			end
			one.insert(one.size(), '{CMD_EDGE_ONE, a, b});
		end
		if (kind <= 6) begin
			// An odd multiplier is a bijection modulo the vertex range.
			mul = VERTEX_W'($urandom) | VERTEX_W'(1);
			off = VERTEX_W'($urandom);
			foreach (one[i]) begin
				a = mul * one[i].vertex_a + off;
				b = mul * one[i].vertex_b + off;
				if ($urandom_range(0, 1) == 1)
					it = '{CMD_EDGE_TWO, a, b};
				else
					it = '{CMD_EDGE_TWO, b, a};
				two.insert($urandom_range(0, two.size()), it);
			end
			if (kind >= 5) begin
				case ($urandom_range(0, 2))
					0: if (two.size() != 0) begin
						idx = $urandom_range(0, two.size() - 1);
						two[idx].vertex_b = VERTEX_W'($urandom);
					end
					1: if (two.size() != 0)
						void'(two.pop_back());
					default: two.insert(two.size(),
						'{CMD_EDGE_TWO, pool[0], VERTEX_W'($urandom)});
				endcase
			end
		end else if (kind != 9) begin
			m = $urandom_range(0, 24);
			for (int i = 0; i < m; i++) begin
				a = (kind == 8) ? VERTEX_W'($urandom) : pool[$urandom_range(0, pool_n - 1)];
				b = (kind == 8) ? VERTEX_W'($urandom) : pool[$urandom_range(0, pool_n - 1)];
				two.insert(two.size(), '{CMD_EDGE_TWO, a, b});
			end
		end
		while (one.size() != 0 || two.size() != 0) begin
			if ($urandom_range(0, 15) == 0)
				send_item(CMD_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom));
			if (two.size() == 0 || (one.size() != 0 && $urandom_range(0, 1) == 1))
				it = one.pop_front();
			else
				it = two.pop_front();
			send_item(it.command, it.vertex_a, it.vertex_b);
		end
		send_item(CMD_COMPARE, VERTEX_W'($urandom), VERTEX_W'($urandom));
	endtask

	task automatic test_random_pairs(int item_goal, int verdict_goal, bit with_idling);
		int first_item;
		int first_verdict;
		first_item    = items_sent;
		first_verdict = compares_sent;
		while (items_sent - first_item < item_goal
				|| compares_sent - first_verdict < verdict_goal) begin
			idling_on = with_idling && ($urandom_range(0, 3) != 0);
			send_graph_pair($urandom_range(0, 9));
			if ($urandom_range(0, 5) == 0)
				wait_for_verdicts(20);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		item_bus.valid       = 1'b0;
		item_bus.command     = CMD_EDGE_ONE;
		item_bus.vertex_a    = '0;
		item_bus.vertex_b    = '0;
		verdict_bus.ready    = 1'b0;
		idling_on            = 1'b0;
		items_sent           = 0;
		compares_sent        = 0;
		verdict_failures     = 0;
		clear_graphs();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_saturation_limits();
		test_random_pairs(450, 15, 1'b1);
		// The last stretch runs with both sides always willing.
		test_random_pairs(150, 5, 1'b0);

		wait_for_verdicts(50);
		if (verdicts_due.size() != 0)
			note_failure("verdicts still outstanding at the end of the run");
		if (verdict_failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, each compare walking every vertex and bin.
	initial begin
		#60_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
